// ===== hdl/sdh_pkg.sv =====
// Shared constants, widths and types of the sample deviation histogram.
package sdh_pkg;

  localparam int CENTER_SAMPLES = 100;
  localparam int GROUPS         = 200;
  localparam int BINS           = 64;

  localparam int SAMPLE_W = 12;
  localparam int SHIFT_W  = 3;
  localparam int CAP_W    = 8;
  localparam int BCNT_W   = 8;
  localparam int BIN_W    = $clog2(BINS);
  localparam int HALF     = BINS / 2;
  localparam int BIN_MAX  = (1 << BCNT_W) - 1;

  // Largest number of samples summed at once: the center phase or the largest group.
  localparam int MAX_GROUP = 1 << ((1 << SHIFT_W) - 1);
  localparam int ACC_SPAN  = (CENTER_SAMPLES > MAX_GROUP) ? CENTER_SAMPLES : MAX_GROUP;
  localparam int ACC_W     = $clog2(ACC_SPAN * (1 << SAMPLE_W));
  localparam int CNT_W     = $clog2(ACC_SPAN + 1);
  localparam int GRP_W     = $clog2(GROUPS + 1);

  // Center = floor(sum / CENTER_SAMPLES) by multiplying with a rounded-up reciprocal.
  localparam int RECIP_SHIFT = 29;
  localparam longint RECIP_MULT =
    ((64'd1 << RECIP_SHIFT) + CENTER_SAMPLES - 1) / CENTER_SAMPLES;
  localparam int MULT_W = $clog2(RECIP_MULT + 1);
  localparam int PROD_W = ACC_W + MULT_W;

  // APB register map
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_SAC_SHIFT = 1'b0;
  localparam logic REG_COUNT_CAP = 1'b1;
  localparam logic [CAP_W-1:0] COUNT_CAP_RESET = CAP_W'(99);

  // Bin memory command from the sequencer: clear sweep or readout address.
  typedef struct packed {
    logic             clear;
    logic [BIN_W-1:0] addr;
  } sdh_mem_cmd_t;

endpackage

// ===== hdl/sdh_ram.sv =====
// Generic simple dual-port RAM with registered read (read-first on collision).
module sdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sdh_bin_update.sv =====
// Bin store: index calculation, read-modify-write with forwarding, clear and readout access.
module sdh_bin_update (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         avg_v,
  input  logic [sdh_pkg::ACC_W-1:0]    avg,
  input  logic [sdh_pkg::SAMPLE_W-1:0] center,
  input  sdh_pkg::sdh_mem_cmd_t        cmd,
  output logic [sdh_pkg::BCNT_W-1:0]   rd_data,
  output logic                         busy
);
  import sdh_pkg::*;

  logic signed [ACC_W+1:0] dev;
  logic [BIN_W-1:0]        idx;
  logic [BIN_W-1:0]        idx_q;
  logic                    idx_v;
  logic [BIN_W-1:0]        wr_addr_q;
  logic [BCNT_W-1:0]       wr_data_q;
  logic                    wr_v_q;
  logic [BCNT_W-1:0]       ram_rdata;
  logic [BCNT_W-1:0]       cur;
  logic [BCNT_W-1:0]       inc;
  logic                    ram_we;
  logic [BIN_W-1:0]        ram_waddr;
  logic [BCNT_W-1:0]       ram_wdata;
  logic [BIN_W-1:0]        ram_raddr;

  // Signed offset of the average from the low edge of the bin window.
  assign dev = $signed({2'b00, avg})
             - $signed({{(ACC_W + 2 - SAMPLE_W){1'b0}}, center})
             + $signed((ACC_W + 2)'(HALF));

  always_comb begin
    if (dev < 0) begin
      idx = '0;
    end else if (dev >= $signed((ACC_W + 2)'(BINS))) begin
      idx = BIN_W'(BINS - 1);
    end else begin
      idx = dev[BIN_W-1:0];
    end
  end

  // Forward the previous write when the read raced it.
  assign cur = (wr_v_q && (wr_addr_q == idx_q)) ? wr_data_q : ram_rdata;
  assign inc = (cur == BCNT_W'(BIN_MAX)) ? cur : cur + 1'b1;

  assign ram_we    = idx_v || cmd.clear;
  assign ram_waddr = idx_v ? idx_q : cmd.addr;
  assign ram_wdata = idx_v ? inc : '0;
  assign ram_raddr = avg_v ? idx : cmd.addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_v  <= 1'b0;
      wr_v_q <= 1'b0;
    end else begin
      idx_v  <= avg_v;
      wr_v_q <= idx_v;
    end
    idx_q     <= idx;
    wr_addr_q <= idx_q;
    wr_data_q <= inc;
  end

  sdh_ram #(
    .WIDTH(BCNT_W),
    .DEPTH(BINS)
  ) u_bin_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_data = ram_rdata;
  assign busy    = idx_v;

endmodule

// ===== hdl/sample_deviation_histogram.sv =====
// Sample deviation histogram top level: sequencer, sample accumulation, center, readout, APB.
//
// Samples are taken one per cycle while the block averages the first 100 samples to a
// center and while it bins averaged groups of 2^sac_shift samples. After the 100th
// sample the input stalls for the reciprocal multiply that forms the center and for a
// sweep that clears the bin RAM one entry a cycle. Each finished group goes through a
// read-modify-write of the dual-port bin RAM (index and read, then increment and write
// back, with forwarding between back-to-back hits on the same bin). After the 200th
// group the input stalls for a drain of that pipeline and then for the readout of 64
// results, one RAM read per result, each read waiting while the output is stalled. The
// last result carries last = 1, and the next run starts in the center phase as that
// result is loaded into the output register.
module sample_deviation_histogram (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [sdh_pkg::SAMPLE_W-1:0]     sample,
  input  logic                             in_valid,
  output logic                             in_stall,
  output logic [sdh_pkg::BIN_W-1:0]        bin_index,
  output logic [sdh_pkg::BCNT_W-1:0]       bin_count,
  output logic [sdh_pkg::SAMPLE_W-1:0]     center_value,
  output logic                             last,
  output logic                             out_valid,
  input  logic                             out_stall,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sdh_pkg::ADDR_W-1:0]       paddr,
  input  logic [sdh_pkg::DATA_W-1:0]       pwdata,
  output logic [sdh_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import sdh_pkg::*;

  typedef enum logic [2:0] {
    ST_CENTER,
    ST_CALC,
    ST_CLEAR,
    ST_HIST,
    ST_DRAIN,
    ST_READ
  } state_t;

  state_t            state;
  logic [SHIFT_W-1:0] sac_shift;
  logic [CAP_W-1:0]  count_cap;
  logic [ACC_W-1:0]  accum;
  logic [CNT_W-1:0]  inner;
  logic [GRP_W-1:0]  group;
  logic [SAMPLE_W-1:0] center;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  avg_q;
  logic              avg_v;
  logic [BIN_W-1:0]  clr_ptr;
  logic [BIN_W-1:0]  rd_ptr;
  logic [BIN_W-1:0]  rd_addr_q;
  logic              rd_last_q;
  logic              rd_inflight;

  logic              in_acc;
  logic              cfg_wr;
  logic              rd_issue;
  logic [ACC_W-1:0]  sum_next;
  logic [CNT_W-1:0]  inner_inc;
  logic [CNT_W-1:0]  grp_size;
  logic [GRP_W-1:0]  grp_inc;
  logic [BCNT_W-1:0] rd_data;
  logic              upd_busy;
  sdh_mem_cmd_t      mem_cmd;

  assign in_stall  = !((state == ST_CENTER) || (state == ST_HIST));
  assign in_acc    = in_valid && !in_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign sum_next  = accum + ACC_W'(sample);
  assign inner_inc = inner + 1'b1;
  assign grp_size  = CNT_W'(1) << sac_shift;
  assign grp_inc   = group + 1'b1;
  assign rd_issue  = (state == ST_READ) && !rd_inflight && (!out_valid || !out_stall);

  assign mem_cmd.clear = (state == ST_CLEAR);
  assign mem_cmd.addr  = (state == ST_CLEAR) ? clr_ptr : rd_ptr;

  always_comb begin
    case (paddr[2])
      REG_SAC_SHIFT: prdata = DATA_W'(sac_shift);
      REG_COUNT_CAP: prdata = DATA_W'(count_cap);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CENTER;
      sac_shift   <= '0;
      count_cap   <= COUNT_CAP_RESET;
      accum       <= '0;
      inner       <= '0;
      group       <= '0;
      center      <= '0;
      avg_v       <= 1'b0;
      clr_ptr     <= '0;
      rd_ptr      <= '0;
      rd_inflight <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      avg_v       <= 1'b0;
      rd_inflight <= rd_issue;

      if (cfg_wr) begin
        case (paddr[2])
          REG_SAC_SHIFT: sac_shift <= pwdata[SHIFT_W-1:0];
          REG_COUNT_CAP: count_cap <= pwdata[CAP_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CENTER: begin
          if (in_acc) begin
            accum <= sum_next;
            if (inner_inc >= CNT_W'(CENTER_SAMPLES)) begin
              inner <= '0;
              state <= ST_CALC;
            end else begin
              inner <= inner_inc;
            end
          end
        end
        ST_CALC: begin
          prod    <= PROD_W'(accum) * PROD_W'(RECIP_MULT);
          clr_ptr <= '0;
          state   <= ST_CLEAR;
        end
        ST_CLEAR: begin
          center  <= prod[RECIP_SHIFT +: SAMPLE_W];
          accum   <= '0;
          group   <= '0;
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == BIN_W'(BINS - 1)) begin
            state <= ST_HIST;
          end
        end
        ST_HIST: begin
          if (in_acc) begin
            if (inner_inc >= grp_size) begin
              // close the group and hand its average to the bin pipeline
              avg_q <= sum_next >> sac_shift;
              avg_v <= 1'b1;
              accum <= '0;
              inner <= '0;
              if (grp_inc >= GRP_W'(GROUPS)) begin
                group <= '0;
                state <= ST_DRAIN;
              end else begin
                group <= grp_inc;
              end
            end else begin
              accum <= sum_next;
              inner <= inner_inc;
            end
          end
        end
        ST_DRAIN: begin
          if (!avg_v && !upd_busy) begin
            rd_ptr <= '0;
            state  <= ST_READ;
          end
        end
        ST_READ: begin
          if (rd_issue) begin
            rd_addr_q <= rd_ptr;
            rd_last_q <= (rd_ptr == BIN_W'(BINS - 1));
            rd_ptr    <= rd_ptr + 1'b1;
          end
          if (rd_inflight) begin
            bin_index    <= rd_addr_q;
            bin_count    <= (rd_data > count_cap) ? count_cap : rd_data;
            center_value <= center;
            last         <= rd_last_q;
            out_valid    <= 1'b1;
            if (rd_last_q) begin
              state <= ST_CENTER;
            end
          end
        end
        default: state <= ST_CENTER;
      endcase
    end
  end

  sdh_bin_update u_bin_update (
    .clk    (clk),
    .rst    (rst),
    .avg_v  (avg_v),
    .avg    (avg_q),
    .center (center),
    .cmd    (mem_cmd),
    .rd_data(rd_data),
    .busy   (upd_busy)
  );

  a_last_is_top_bin: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> bin_index == BIN_W'(BINS - 1))
    else $error("last flag on a bin other than the top bin");

  a_read_after_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !avg_v && !upd_busy)
    else $error("readout while a bin update is in flight");

  a_clear_no_update: assert property (@(posedge clk) disable iff (rst)
    mem_cmd.clear |-> !upd_busy && !avg_v)
    else $error("bin clear overlaps a bin update");

  a_no_input_in_readout: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN || state == ST_READ) |=> !(avg_v && $past(state) == ST_READ))
    else $error("group completed during readout");

endmodule

// ===== tb/sample_deviation_histogram_tb.sv =====
// Self-checking testbench of the sample deviation histogram: predictor, driver, monitor and APB.
module sample_deviation_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sdh_pkg::*;

  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 10;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

  typedef enum logic {PH_CENTER, PH_HIST} run_phase_t;

  typedef struct packed {
    logic [BIN_W-1:0]    idx;
    logic [BCNT_W-1:0]   cnt;
    logic [SAMPLE_W-1:0] center;
    logic                last;
  } bin_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BIN_W-1:0]    bin_index;
  logic [BCNT_W-1:0]   bin_count;
  logic [SAMPLE_W-1:0] center_value;
  logic                last;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  sample_deviation_histogram dut (
    .clk(clk), .rst(rst),
    .sample(sample), .in_valid(in_valid), .in_stall(in_stall),
    .bin_index(bin_index), .bin_count(bin_count), .center_value(center_value),
    .last(last), .out_valid(out_valid), .out_stall(out_stall),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // register copy
  logic [SHIFT_W-1:0] shift_set = '0;
  logic [CAP_W-1:0]   cap_set = COUNT_CAP_RESET;

  // histogram prediction state
  run_phase_t          phase = PH_CENTER;
  int unsigned         acc_sum = 0;
  int unsigned         acc_n = 0;
  int unsigned         group_n = 0;
  logic [SAMPLE_W-1:0] center_est = '0;
  int unsigned         tally [BINS] = '{default: 0};

  bin_result_t         bins_due [$];
  logic [SAMPLE_W-1:0] sample_q [$];

  int errors = 0;
  int items_taken = 0;
  int results_seen = 0;
  int runs_done = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit idle_on = 1'b1;
  bit hold_armed = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // Advance the histogram by one accepted sample; queue the bin readout on the last group.
  task automatic tally_sample(input logic [SAMPLE_W-1:0] s);
    int          avg;
    int          slot;
    bin_result_t r;
    acc_sum += s;
    acc_n++;
    if (phase == PH_CENTER) begin
      if (acc_n >= CENTER_SAMPLES) begin
        center_est = SAMPLE_W'(acc_sum / CENTER_SAMPLES);
        acc_sum = 0;
        acc_n = 0;
        group_n = 0;
        foreach (tally[i]) tally[i] = 0;
        phase = PH_HIST;
      end
    end else if (acc_n >= (1 << shift_set)) begin
      avg = int'(acc_sum >> shift_set);
      // signed window around the center, outliers clamp to the end bins
      if (avg < int'(center_est) - HALF) slot = 0;
      else if (avg >= int'(center_est) + HALF) slot = BINS - 1;
      else slot = avg - int'(center_est) + HALF;
      if (tally[slot] < BIN_MAX) tally[slot]++;
      acc_sum = 0;
      acc_n = 0;
      group_n++;
      if (group_n >= GROUPS) begin
        for (int i = 0; i < BINS; i++) begin
          r.idx    = BIN_W'(i);
          r.cnt    = (tally[i] > cap_set) ? cap_set : BCNT_W'(tally[i]);
          r.center = center_est;
          r.last   = (i == BINS - 1);
          bins_due.push_back(r);
        end
        group_n = 0;
        phase = PH_CENTER;
        runs_done++;
      end
    end
  endtask

  // sample sender
  always @(posedge clk) begin
    logic                vld_n;
    logic [SAMPLE_W-1:0] smp_n;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      vld_n = in_valid;
      smp_n = sample;
      if (in_valid && !in_stall) begin
        tally_sample(sample);
        items_taken++;
        vld_n = 1'b0;
      end
      if (!vld_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_q.size() > 0) begin
          if (idle_on && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 15);
          end else begin
            vld_n = 1'b1;
            smp_n = sample_q.pop_front();
          end
        end
      end
      in_valid <= vld_n;
      sample <= smp_n;
    end
  end

  // result receiver and checker
  always @(posedge clk) begin
    bin_result_t got;
    bin_result_t want;
    logic        stall_n;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{bin_index, bin_count, center_value, last};
        if (bins_due.size() == 0) begin
          flag_error($sformatf("unexpected item idx=%0d cnt=%0d center=%0d last=%0b",
                               bin_index, bin_count, center_value, last));
        end else begin
          want = bins_due.pop_front();
          results_seen++;
          if (got !== want)
            flag_error($sformatf({"expected idx=%0d cnt=%0d center=%0d last=%0b, ",
                                  "got idx=%0d cnt=%0d center=%0d last=%0b"},
                                 want.idx, want.cnt, want.center, want.last,
                                 got.idx, got.cnt, got.center, got.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_n = 1'b1;
      end else if (hold_armed && out_valid) begin
        // hold off long enough for the block to back up into its input
        hold_armed = 1'b0;
        hold_left = LONG_HOLD - 1;
        stall_n = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_n = 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        stall_n = 1'b1;
      end else begin
        stall_n = 1'b0;
      end
      out_stall <= stall_n;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("cycle limit of %0d reached", LIMIT_CYCLES);
      $display("status: fail");
      $finish;
    end
  end

  task automatic apb_cycle(input logic sel, input logic wr, input logic [DATA_W-1:0] val,
                           output logic [DATA_W-1:0] rd);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {sel, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reg_write(input logic sel, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] unused;
    apb_cycle(sel, 1'b1, val, unused);
    if (sel == REG_SAC_SHIFT) shift_set = val[SHIFT_W-1:0];
    else cap_set = val[CAP_W-1:0];
  endtask

  task automatic reg_check(input logic sel);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] want;
    apb_cycle(sel, 1'b0, '0, rd);
    want = (sel == REG_SAC_SHIFT) ? DATA_W'(shift_set) : DATA_W'(cap_set);
    if (rd !== want)
      flag_error($sformatf("register %0d read %0h, expected %0h", sel, rd, want));
  endtask

  // Wait until every sample is taken and every bin result is back, then let the block go idle.
  task automatic settle();
    @(negedge clk);
    while (sample_q.size() != 0 || in_valid || bins_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] near(input int base, input int spread);
    int v;
    v = base - spread + int'($urandom_range(0, 2 * spread));
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  // group samples around a base, one in eight anywhere in the ADC range
  task automatic plan_groups(input int base, input int spread, input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) sample_q.push_back(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
      else sample_q.push_back(near(base, spread));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    reg_check(REG_SAC_SHIFT);
    reg_check(REG_COUNT_CAP);
    // upper bits of the cap write are dropped
    reg_write(REG_COUNT_CAP, 32'hFFFF_FF05);
    reg_check(REG_COUNT_CAP);

    // center below half the window: alternating 0 and 24 average to 12
    for (int i = 0; i < CENTER_SAMPLES; i++)
      sample_q.push_back((i % 2) ? SAMPLE_W'(24) : '0);
    // rails, the top window edge and one past it, then one bin driven past the cap
    sample_q.push_back('0);
    sample_q.push_back('1);
    sample_q.push_back(SAMPLE_W'(42));
    sample_q.push_back(SAMPLE_W'(43));
    sample_q.push_back(SAMPLE_W'(44));
    sample_q.push_back(SAMPLE_W'(12));
    repeat (30) sample_q.push_back(SAMPLE_W'(12));
    plan_groups(12, 30, 100);
    settle();

    // twenty groups of two; upper bits of the shift write are dropped
    reg_write(REG_SAC_SHIFT, 32'hFFFF_FFF9);
    reg_check(REG_SAC_SHIFT);
    plan_groups(12, 30, 40);
    settle();

    // drop the shift inside a group: six full-scale samples unshifted overflow the range
    reg_write(REG_SAC_SHIFT, 3);
    repeat (5) sample_q.push_back('1);
    settle();
    idle_on = 1'b0;
    reg_write(REG_SAC_SHIFT, 32'hFFFF_FFF8);
    reg_check(REG_SAC_SHIFT);
    sample_q.push_back('1);

    // 157 groups so far; finish the run and hold off during its readout
    hold_armed = 1'b1;
    plan_groups(12, 30, GROUPS - 157);
    // start of the next run, offered while the receiver holds off
    for (int i = 0; i < CENTER_SAMPLES; i++) sample_q.push_back(near(4060, 35));
    plan_groups(4060, 35, 25);
    settle();

    if (bins_due.size() != 0) flag_error($sformatf("%0d bin results never came", bins_due.size()));
    $display("covered %0d samples and %0d bin results over %0d full runs",
             items_taken, results_seen, runs_done);
    $display("low center, rails, window edge, cap clamp, shifts 0/1/3, a %0d-cycle hold",
             LONG_HOLD);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sdh_pkg.sv
hdl/sdh_ram.sv
hdl/sdh_bin_update.sv
hdl/sample_deviation_histogram.sv
tb/sample_deviation_histogram_tb.sv
